[sv/ttrs_pkg.sv]
// ----------------------------------------------------------------------------
// ttrs_pkg
// Shared sizes, command codes, sequencer states and FIFO control type.
// ----------------------------------------------------------------------------
package ttrs_pkg;

    localparam int TASKS          = 24;
    localparam int BASES          = 3;
    localparam int SLOTS_PER_BASE = 8;
    localparam int PERIOD_BITS    = 16;

    localparam int NSLOTS  = BASES * SLOTS_PER_BASE;
    localparam int SLOT_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int TASK_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int IDX_W   = (SLOT_W > TASK_W) ? SLOT_W : TASK_W;
    localparam int QCNT_W  = $clog2(TASKS + 1);
    localparam int PER_W   = (PERIOD_BITS < 16) ? PERIOD_BITS : 16;

    localparam logic [TASKS-1:0] ENABLE_RESET = TASKS'(32'h00F0_0FFF);

    typedef enum logic [3:0] {
        CMD_REQUEST     = 4'd0,
        CMD_ENABLE      = 4'd1,
        CMD_DISABLE     = 4'd2,
        CMD_SUBSCRIBE   = 4'd3,
        CMD_UNSUBSCRIBE = 4'd4,
        CMD_RESUBSCRIBE = 4'd5,
        CMD_TICK        = 4'd6,
        CMD_COLLECT     = 4'd7,
        CMD_POP         = 4'd8,
        CMD_QUERY       = 4'd9
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [4:0] data;
    } fifo_ctrl_t;

endpackage

[sv/ttrs_ready_fifo.sv]
// ----------------------------------------------------------------------------
// ttrs_ready_fifo
// Ready queue of task ids; push drops when full, pop data is registered.
// ----------------------------------------------------------------------------
module ttrs_ready_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ttrs_pkg::fifo_ctrl_t        ctrl,
    output logic [4:0]                  rd_data,
    output logic [ttrs_pkg::QCNT_W-1:0] count
);

    logic [4:0]                  mem [ttrs_pkg::TASKS];
    logic [ttrs_pkg::TASK_W-1:0] head_reg, tail_reg;
    logic [ttrs_pkg::QCNT_W-1:0] count_reg;
    logic [4:0]                  rd_data_reg;
    logic                        do_push, do_pop;

    assign do_push = ctrl.push && (count_reg < ttrs_pkg::QCNT_W'(ttrs_pkg::TASKS));
    assign do_pop  = ctrl.pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail_reg] <= ctrl.data;
        end
        if (do_pop) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                tail_reg <= (tail_reg == ttrs_pkg::TASK_W'(ttrs_pkg::TASKS - 1)) ? '0
                            : tail_reg + 1'b1;
            end
            if (do_pop) begin
                head_reg <= (head_reg == ttrs_pkg::TASK_W'(ttrs_pkg::TASKS - 1)) ? '0
                            : head_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

[sv/timed_task_request_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// timed_task_request_scheduler_unit
// Task request scheduler: pending/enable bitmaps, ready queue, timer slots.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    command task_number time_base slot_handle
//                                  period one_shot
// m_       out  m_valid/m_ready    accepted handle_out handle_valid
//                                  dispatch_valid dispatch_task task_is_enabled
//                                  power_level queue_fill
//
// One request at a time. Simple commands pass through accept, execute and
// result steps. Disable walks all slots, subscribe and tick walk the slots
// of one base, collect walks all tasks: one entry per cycle through the
// shared slot/task walker, ahead of the result step.
// Reset (synchronous, aresetn low) clears bitmaps, queue pointers and slot
// active bits; enable bits take their default pattern.
// A held result (m_ready low) stalls only the final step; a new request is
// taken as soon as the result is registered.
// ----------------------------------------------------------------------------
module timed_task_request_scheduler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [4:0]  s_task_number,
    input  logic [1:0]  s_time_base,
    input  logic [3:0]  s_slot_handle,
    input  logic [15:0] s_period,
    input  logic        s_one_shot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [3:0]  m_handle_out,
    output logic        m_handle_valid,
    output logic        m_dispatch_valid,
    output logic [4:0]  m_dispatch_task,
    output logic        m_task_is_enabled,
    output logic [1:0]  m_power_level,
    output logic [4:0]  m_queue_fill
);

    localparam int NS = ttrs_pkg::NSLOTS;
    localparam int TW = ttrs_pkg::TASK_W;
    localparam int SW = ttrs_pkg::SLOT_W;
    localparam int PW = ttrs_pkg::PER_W;

    // sequencer and latched request
    ttrs_pkg::state_t state_reg;
    ttrs_pkg::cmd_t   cmd_reg;
    logic [4:0]       task_reg;
    logic [1:0]       base_reg;
    logic [3:0]       hnd_reg;
    logic [PW-1:0]    per_reg;
    logic             once_reg;

    // walker
    logic [ttrs_pkg::IDX_W-1:0] idx_reg, last_reg;
    logic [ttrs_pkg::TASKS-1:0] bits_reg;   // pending snapshot for collect

    // bitmaps
    logic [ttrs_pkg::TASKS-1:0] pending_reg, enable_reg;

    // slot storage; only active bits are reset
    logic [NS-1:0]  slot_active_reg;
    logic           slot_once  [NS];
    logic [4:0]     slot_task  [NS];
    logic [PW-1:0]  slot_cnt   [NS];
    logic [PW-1:0]  slot_rld   [NS];

    // partial result
    logic       acc_reg, hval_reg, popped_reg, qen_reg;
    logic [3:0] hout_reg;

    // result register
    logic       m_valid_reg, o_acc_reg, o_hval_reg, o_dval_reg, o_qen_reg;
    logic [3:0] o_hout_reg;
    logic [4:0] o_dtask_reg, o_fill_reg;
    logic [1:0] o_sleep_reg;

    // queue
    ttrs_pkg::fifo_ctrl_t        fifo_ctrl;
    logic [4:0]                  fifo_rd;
    logic [ttrs_pkg::QCNT_W-1:0] fifo_count;

    ttrs_ready_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .rd_data (fifo_rd),
        .count   (fifo_count)
    );

    // argument checks
    logic          task_ok, base_ok, hnd_ok, per_ok;
    logic [SW-1:0] base_start, hnd_slot, sidx;
    logic [PW-1:0] cnt_dec;
    logic [NS-1:0] snooze_mask;
    logic          task_en, walk_end, slot_task_ok;

    assign task_ok    = ({1'b0, task_reg} < 6'(ttrs_pkg::TASKS));
    assign base_ok    = (base_reg < 2'(ttrs_pkg::BASES > 3 ? 3 : ttrs_pkg::BASES))
                        || (ttrs_pkg::BASES > 3);
    assign hnd_ok     = ({1'b0, hnd_reg} < 5'(ttrs_pkg::SLOTS_PER_BASE));
    assign per_ok     = (per_reg != '0);
    assign base_start = SW'(base_reg * ttrs_pkg::SLOTS_PER_BASE);
    assign hnd_slot   = SW'(base_reg * ttrs_pkg::SLOTS_PER_BASE + hnd_reg);
    assign task_en    = task_ok && enable_reg[task_reg[TW-1:0]];
    assign sidx       = idx_reg[SW-1:0];
    assign cnt_dec    = slot_cnt[sidx] - 1'b1;
    assign walk_end   = (idx_reg == last_reg);
    assign slot_task_ok = ({1'b0, slot_task[sidx]} < 6'(ttrs_pkg::TASKS));

    // slots of the fast and medium bases keep the block snoozing
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            snooze_mask[i] = (i < 2 * ttrs_pkg::SLOTS_PER_BASE);
        end
    end

    // queue control: collect pushes during the walk, pop issues in execute
    always_comb begin
        fifo_ctrl.push = (state_reg == ttrs_pkg::ST_WALK) && (cmd_reg == ttrs_pkg::CMD_COLLECT)
                         && bits_reg[idx_reg[TW-1:0]];
        fifo_ctrl.pop  = (state_reg == ttrs_pkg::ST_EXEC) && (cmd_reg == ttrs_pkg::CMD_POP);
        fifo_ctrl.data = 5'(idx_reg);
    end

    assign s_ready = (state_reg == ttrs_pkg::ST_IDLE);

    // slot payload storage
    always_ff @(posedge aclk) begin
        if (state_reg == ttrs_pkg::ST_EXEC && cmd_reg == ttrs_pkg::CMD_RESUBSCRIBE
            && base_ok && hnd_ok && per_ok && slot_active_reg[hnd_slot]) begin
            slot_cnt[hnd_slot] <= per_reg;
            slot_rld[hnd_slot] <= per_reg;
        end
        if (state_reg == ttrs_pkg::ST_WALK) begin
            if (cmd_reg == ttrs_pkg::CMD_SUBSCRIBE && !slot_active_reg[sidx]) begin
                slot_once[sidx] <= once_reg;
                slot_task[sidx] <= task_reg;
                slot_cnt[sidx]  <= per_reg;
                slot_rld[sidx]  <= per_reg;
            end
            if (cmd_reg == ttrs_pkg::CMD_TICK && slot_active_reg[sidx]) begin
                slot_cnt[sidx] <= (cnt_dec == '0) ? slot_rld[sidx] : cnt_dec;
            end
        end
    end

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ttrs_pkg::ST_IDLE;
            pending_reg     <= '0;
            enable_reg      <= ttrs_pkg::ENABLE_RESET;
            slot_active_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // a result taken in DONE is replaced there by the next one
            if (m_valid_reg && m_ready && state_reg != ttrs_pkg::ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ttrs_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= ttrs_pkg::cmd_t'(s_command);
                        task_reg   <= s_task_number;
                        base_reg   <= s_time_base;
                        hnd_reg    <= s_slot_handle;
                        per_reg    <= s_period[PW-1:0];
                        once_reg   <= s_one_shot;
                        acc_reg    <= 1'b0;
                        hval_reg   <= 1'b0;
                        hout_reg   <= '0;
                        popped_reg <= 1'b0;
                        qen_reg    <= 1'b0;
                        state_reg  <= ttrs_pkg::ST_EXEC;
                    end
                end
                ttrs_pkg::ST_EXEC: begin
                    state_reg <= ttrs_pkg::ST_DONE;
                    case (cmd_reg)
                        ttrs_pkg::CMD_REQUEST: begin
                            if (task_en) begin
                                pending_reg[task_reg[TW-1:0]] <= 1'b1;
                                acc_reg <= 1'b1;
                            end
                        end
                        ttrs_pkg::CMD_ENABLE: begin
                            if (task_ok) begin
                                enable_reg[task_reg[TW-1:0]] <= 1'b1;
                                acc_reg <= 1'b1;
                            end
                        end
                        ttrs_pkg::CMD_DISABLE: begin
                            if (task_ok) begin
                                enable_reg[task_reg[TW-1:0]] <= 1'b0;
                                acc_reg   <= 1'b1;
                                idx_reg   <= '0;
                                last_reg  <= ttrs_pkg::IDX_W'(NS - 1);
                                state_reg <= ttrs_pkg::ST_WALK;
                            end
                        end
                        ttrs_pkg::CMD_SUBSCRIBE: begin
                            if (task_ok && base_ok && per_ok) begin
                                idx_reg   <= ttrs_pkg::IDX_W'(base_start);
                                last_reg  <= ttrs_pkg::IDX_W'(base_start)
                                             + ttrs_pkg::IDX_W'(ttrs_pkg::SLOTS_PER_BASE - 1);
                                state_reg <= ttrs_pkg::ST_WALK;
                            end
                        end
                        ttrs_pkg::CMD_UNSUBSCRIBE: begin
                            if (base_ok && hnd_ok) begin
                                slot_active_reg[hnd_slot] <= 1'b0;
                                acc_reg <= 1'b1;
                            end
                        end
                        ttrs_pkg::CMD_RESUBSCRIBE: begin
                            if (base_ok && hnd_ok && per_ok && slot_active_reg[hnd_slot]) begin
                                acc_reg <= 1'b1;
                            end
                        end
                        ttrs_pkg::CMD_TICK: begin
                            if (base_ok) begin
                                acc_reg   <= 1'b1;
                                idx_reg   <= ttrs_pkg::IDX_W'(base_start);
                                last_reg  <= ttrs_pkg::IDX_W'(base_start)
                                             + ttrs_pkg::IDX_W'(ttrs_pkg::SLOTS_PER_BASE - 1);
                                state_reg <= ttrs_pkg::ST_WALK;
                            end
                        end
                        ttrs_pkg::CMD_COLLECT: begin
                            bits_reg    <= pending_reg;
                            pending_reg <= '0;
                            acc_reg     <= 1'b1;
                            idx_reg     <= '0;
                            last_reg    <= ttrs_pkg::IDX_W'(ttrs_pkg::TASKS - 1);
                            state_reg   <= ttrs_pkg::ST_WALK;
                        end
                        ttrs_pkg::CMD_POP: begin
                            if (fifo_count != '0) begin
                                popped_reg <= 1'b1;
                                acc_reg    <= 1'b1;
                            end
                        end
                        ttrs_pkg::CMD_QUERY: begin
                            if (task_ok) begin
                                qen_reg <= task_en;
                                acc_reg <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ttrs_pkg::ST_WALK: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (walk_end) begin
                        state_reg <= ttrs_pkg::ST_DONE;
                    end
                    case (cmd_reg)
                        ttrs_pkg::CMD_DISABLE: begin
                            if (slot_task[sidx] == task_reg) begin
                                slot_active_reg[sidx] <= 1'b0;
                            end
                        end
                        ttrs_pkg::CMD_SUBSCRIBE: begin
                            // first free slot wins and ends the walk
                            if (!slot_active_reg[sidx]) begin
                                slot_active_reg[sidx] <= 1'b1;
                                acc_reg   <= 1'b1;
                                hval_reg  <= 1'b1;
                                hout_reg  <= 4'(sidx - base_start);
                                state_reg <= ttrs_pkg::ST_DONE;
                            end
                        end
                        ttrs_pkg::CMD_TICK: begin
                            if (slot_active_reg[sidx] && cnt_dec == '0) begin
                                if (slot_task_ok && enable_reg[slot_task[sidx][TW-1:0]]) begin
                                    pending_reg[slot_task[sidx][TW-1:0]] <= 1'b1;
                                end
                                if (slot_once[sidx]) begin
                                    slot_active_reg[sidx] <= 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ttrs_pkg::ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        o_acc_reg   <= acc_reg;
                        o_hout_reg  <= hout_reg;
                        o_hval_reg  <= hval_reg;
                        o_dval_reg  <= popped_reg && ({1'b0, fifo_rd} < 6'(ttrs_pkg::TASKS))
                                       && enable_reg[fifo_rd[TW-1:0]];
                        o_dtask_reg <= popped_reg ? fifo_rd : 5'd0;
                        o_qen_reg   <= qen_reg;
                        o_fill_reg  <= 5'(fifo_count);
                        priority if (fifo_count != '0) begin
                            o_sleep_reg <= 2'd0;
                        end else if ((slot_active_reg & snooze_mask) != '0) begin
                            o_sleep_reg <= 2'd1;
                        end else begin
                            o_sleep_reg <= 2'd2;
                        end
                        state_reg <= ttrs_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ttrs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = o_acc_reg;
    assign m_handle_out      = o_hout_reg;
    assign m_handle_valid    = o_hval_reg;
    assign m_dispatch_valid  = o_dval_reg;
    assign m_dispatch_task   = o_dtask_reg;
    assign m_task_is_enabled = o_qen_reg;
    assign m_power_level     = o_sleep_reg;
    assign m_queue_fill      = o_fill_reg;

endmodule

[sv/ttrs_checker.sv]
// ----------------------------------------------------------------------------
// ttrs_checker
// Port-level checks on the scheduler result channel.
// ----------------------------------------------------------------------------
module ttrs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_accepted,
    input logic        m_handle_valid,
    input logic        m_dispatch_valid,
    input logic [4:0]  m_dispatch_task,
    input logic [1:0]  m_power_level,
    input logic [4:0]  m_queue_fill
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dispatch_task))
        else $error("result changed while stalled");

    a_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_handle_valid |-> m_accepted)
        else $error("handle granted without acceptance");

    a_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dispatch_valid |-> m_accepted)
        else $error("dispatch without acceptance");

    a_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_queue_fill != 5'd0 |-> m_power_level == 2'd0)
        else $error("sleeping with queued tasks");

    a_sleep_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_queue_fill == 5'd0 |-> m_power_level != 2'd0)
        else $error("run level with empty queue");

endmodule

bind timed_task_request_scheduler_unit ttrs_checker u_ttrs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_accepted       (m_accepted),
    .m_handle_valid   (m_handle_valid),
    .m_dispatch_valid (m_dispatch_valid),
    .m_dispatch_task  (m_dispatch_task),
    .m_power_level    (m_power_level),
    .m_queue_fill     (m_queue_fill)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the task request scheduler unit.
// A scoreboard model tracks bitmaps, ready queue and timer slots; every
// request's result is predicted at acceptance and compared when it returns.
// ----------------------------------------------------------------------------
module testbench;
    import ttrs_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_command = '0;
    logic [4:0]  s_task_number = '0;
    logic [1:0]  s_time_base = '0;
    logic [3:0]  s_slot_handle = '0;
    logic [15:0] s_period = '0;
    logic        s_one_shot = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic [3:0]  m_handle_out;
    logic        m_handle_valid;
    logic        m_dispatch_valid;
    logic [4:0]  m_dispatch_task;
    logic        m_task_is_enabled;
    logic [1:0]  m_power_level;
    logic [4:0]  m_queue_fill;

    timed_task_request_scheduler_unit uut (.*);

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic       accepted;
        logic [3:0] handle_out;
        logic       handle_valid;
        logic       dispatch_valid;
        logic [4:0] dispatch_task;
        logic       task_is_enabled;
        logic [1:0] power_level;
        logic [4:0] queue_fill;
    } sched_result_t;

    // scheduler state mirror
    logic [TASKS-1:0]  mdl_pending;
    logic [TASKS-1:0]  mdl_enable;
    logic [4:0]        mdl_queue [TASKS];
    int                mdl_head, mdl_tail, mdl_count;
    logic              mdl_active [NSLOTS];
    logic              mdl_once [NSLOTS];
    logic [4:0]        mdl_owner [NSLOTS];
    logic [15:0]       mdl_count_down [NSLOTS];
    logic [15:0]       mdl_reload [NSLOTS];

    sched_result_t pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    function automatic void mdl_request(input logic [4:0] t, output logic ok);
        ok = 1'b0;
        if (t < TASKS && mdl_enable[t]) begin
            mdl_pending[t] = 1'b1;
            ok = 1'b1;
        end
    endfunction

    function automatic sched_result_t predict_step(input logic [3:0] cmd,
            input logic [4:0] t, input logic [1:0] b, input logic [3:0] h,
            input logic [15:0] per, input logic once);
        sched_result_t r;
        logic ok;
        logic [TASKS-1:0] bits;
        int s;
        logic task_ok, base_ok;
        r = '0;
        task_ok = t < TASKS;
        base_ok = b < BASES;
        case (cmd)
            CMD_REQUEST: begin
                mdl_request(t, ok);
                r.accepted = ok;
            end
            CMD_ENABLE: if (task_ok) begin
                mdl_enable[t] = 1'b1;
                r.accepted = 1'b1;
            end
            CMD_DISABLE: if (task_ok) begin
                mdl_enable[t] = 1'b0;
                for (int i = 0; i < NSLOTS; i++)
                    if (mdl_active[i] && mdl_owner[i] == t) mdl_active[i] = 1'b0;
                r.accepted = 1'b1;
            end
            CMD_SUBSCRIBE: if (task_ok && base_ok && per != 0) begin
                for (int i = 0; i < SLOTS_PER_BASE; i++) begin
                    s = b * SLOTS_PER_BASE + i;
                    if (!mdl_active[s] && !r.handle_valid) begin
                        mdl_active[s] = 1'b1;
                        mdl_once[s] = once;
                        mdl_owner[s] = t;
                        mdl_count_down[s] = per;
                        mdl_reload[s] = per;
                        r.accepted = 1'b1;
                        r.handle_valid = 1'b1;
                        r.handle_out = 4'(i);
                    end
                end
            end
            CMD_UNSUBSCRIBE: if (base_ok && h < SLOTS_PER_BASE) begin
                mdl_active[b * SLOTS_PER_BASE + h] = 1'b0;
                r.accepted = 1'b1;
            end
            CMD_RESUBSCRIBE: if (base_ok && h < SLOTS_PER_BASE && per != 0) begin
                s = b * SLOTS_PER_BASE + h;
                if (mdl_active[s]) begin
                    mdl_count_down[s] = per;
                    mdl_reload[s] = per;
                    r.accepted = 1'b1;
                end
            end
            CMD_TICK: if (base_ok) begin
                for (int i = 0; i < SLOTS_PER_BASE; i++) begin
                    s = b * SLOTS_PER_BASE + i;
                    if (mdl_active[s]) begin
                        mdl_count_down[s] = mdl_count_down[s] - 16'd1;
                        if (mdl_count_down[s] == 0) begin
                            mdl_request(mdl_owner[s], ok);
                            if (mdl_once[s]) mdl_active[s] = 1'b0;
                            else mdl_count_down[s] = mdl_reload[s];
                        end
                    end
                end
                r.accepted = 1'b1;
            end
            CMD_COLLECT: begin
                bits = mdl_pending;
                mdl_pending = '0;
                for (int i = 0; i < TASKS; i++)
                    if (bits[i] && mdl_count < TASKS) begin
                        mdl_queue[mdl_tail] = 5'(i);
                        mdl_tail = (mdl_tail + 1) % TASKS;
                        mdl_count++;
                    end
                r.accepted = 1'b1;
            end
            CMD_POP: if (mdl_count > 0) begin
                r.dispatch_task = mdl_queue[mdl_head];
                mdl_head = (mdl_head + 1) % TASKS;
                mdl_count--;
                r.dispatch_valid = mdl_enable[r.dispatch_task];
                r.accepted = 1'b1;
            end
            CMD_QUERY: if (task_ok) begin
                r.task_is_enabled = mdl_enable[t];
                r.accepted = 1'b1;
            end
            default: ;
        endcase
        // power level after the command
        if (mdl_count > 0) r.power_level = 2'd0;
        else begin
            r.power_level = 2'd2;
            for (int i = 0; i < 2 * SLOTS_PER_BASE && i < NSLOTS; i++)
                if (mdl_active[i]) r.power_level = 2'd1;
        end
        r.queue_fill = 5'(mdl_count);
        return r;
    endfunction

    // send one request; prediction happens at the accepting edge
    // valid stays up into the next request unless the sender idles
    task automatic send_request(input logic [3:0] cmd, input logic [4:0] t,
            input logic [1:0] b, input logic [3:0] h, input logic [15:0] per,
            input logic once);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_task_number <= t;
        s_time_base   <= b;
        s_slot_handle <= h;
        s_period      <= per;
        s_one_shot    <= once;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_step(cmd, t, b, h, per, once));
    endtask

    // receiver: random stalls, checks every accepted result
    always @(posedge aclk) begin
        sched_result_t e;
        cycles++;
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_accepted !== e.accepted) begin
                    $error("accepted exp %0d got %0d", e.accepted, m_accepted); errors++;
                end
                if (m_handle_out !== e.handle_out) begin
                    $error("handle_out exp %0d got %0d", e.handle_out, m_handle_out);
                    errors++;
                end
                if (m_handle_valid !== e.handle_valid) begin
                    $error("handle_valid exp %0d got %0d", e.handle_valid, m_handle_valid);
                    errors++;
                end
                if (m_dispatch_valid !== e.dispatch_valid) begin
                    $error("dispatch_valid exp %0d got %0d", e.dispatch_valid,
                           m_dispatch_valid);
                    errors++;
                end
                if (m_dispatch_task !== e.dispatch_task) begin
                    $error("dispatch_task exp %0d got %0d", e.dispatch_task,
                           m_dispatch_task);
                    errors++;
                end
                if (m_task_is_enabled !== e.task_is_enabled) begin
                    $error("task_is_enabled exp %0d got %0d", e.task_is_enabled,
                           m_task_is_enabled);
                    errors++;
                end
                if (m_power_level !== e.power_level) begin
                    $error("power_level exp %0d got %0d", e.power_level, m_power_level);
                    errors++;
                end
                if (m_queue_fill !== e.queue_fill) begin
                    $error("queue_fill exp %0d got %0d", e.queue_fill, m_queue_fill);
                    errors++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // edge cases: invalid ids, bases, handles, zero period, full slot bank
    task automatic test_directed();
        send_request(CMD_QUERY, 5'd31, 0, 0, 0, 0);
        send_request(CMD_QUERY, 5'd12, 0, 0, 0, 0);
        send_request(CMD_POP, 0, 0, 0, 0, 0);
        send_request(CMD_REQUEST, 5'd24, 0, 0, 0, 0);
        send_request(CMD_REQUEST, 5'd12, 0, 0, 0, 0);
        send_request(CMD_REQUEST, 5'd0, 0, 0, 0, 0);
        send_request(CMD_ENABLE, 5'd23, 0, 0, 0, 0);
        send_request(CMD_SUBSCRIBE, 5'd1, 2'd3, 0, 16'd5, 0);
        send_request(CMD_SUBSCRIBE, 5'd1, 2'd0, 0, 16'd0, 0);
        for (int i = 0; i < 9; i++)
            send_request(CMD_SUBSCRIBE, 5'(i), 2'd0, 0, (i == 0) ? 16'hFFFF : 16'd1, 1'b1);
        send_request(CMD_RESUBSCRIBE, 0, 2'd1, 4'd15, 16'd3, 0);
        send_request(CMD_RESUBSCRIBE, 0, 2'd1, 4'd2, 16'd3, 0);
        send_request(CMD_TICK, 0, 2'd0, 0, 0, 0);
        send_request(CMD_TICK, 0, 2'd3, 0, 0, 0);
        send_request(CMD_UNSUBSCRIBE, 0, 2'd0, 4'd8, 0, 0);
        send_request(CMD_DISABLE, 5'd0, 0, 0, 0, 0);
        send_request(CMD_COLLECT, 0, 0, 0, 0, 0);
        send_request(4'd15, 5'h1F, 2'd3, 4'hF, 16'hFFFF, 1'b1);
        send_request(CMD_POP, 0, 0, 0, 0, 0);
    endtask

    // mostly well-formed traffic biased toward valid ids and small periods
    task automatic test_random(input int n);
        logic [3:0] cmd;
        logic [4:0] t;
        logic [1:0] b;
        logic [3:0] h;
        logic [15:0] per;
        for (int i = 0; i < n; i++) begin
            cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                            : 4'($urandom_range(9));
            t   = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(TASKS - 1));
            b   = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(BASES - 1));
            h   = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(7));
            per = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6));
            send_request(cmd, t, b, h, per, 1'($urandom));
        end
    endtask

    // fill the ready queue past its capacity, then drain it
    task automatic test_queue_overflow();
        for (int k = 0; k < 2; k++) begin
            for (int t = 0; t < TASKS; t++) send_request(CMD_ENABLE, 5'(t), 0, 0, 0, 0);
            for (int t = 0; t < TASKS; t++) send_request(CMD_REQUEST, 5'(t), 0, 0, 0, 0);
            send_request(CMD_COLLECT, 0, 0, 0, 0, 0);
        end
        for (int t = 0; t < TASKS + 1; t++) send_request(CMD_POP, 0, 0, 0, 0, 0);
    endtask

    initial begin
        // mirror starts in the reset state
        mdl_pending = '0;
        mdl_enable  = ENABLE_RESET;
        for (int i = 0; i < NSLOTS; i++) mdl_active[i] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        wait_drained();           // sender holds off until everything is back
        send_idle_pct = 35; recv_idle_pct = 64;
        test_random(450);
        send_idle_pct = 64; recv_idle_pct = 35;
        test_random(450);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_queue_overflow();
        test_random(450);
        wait_drained();
        repeat (40) @(posedge aclk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
